@@ rtl/core/stcs_pkg.sv @@
// ----------------------------------------------------------------------------
// stcs_pkg
// Shared widths, types, register indexes and helpers for the sphere and
// triangle collision step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stcs_pkg;

  localparam int unsigned CoordW   = 21;
  localparam int unsigned RadW     = 20;
  localparam int unsigned DtW      = 16;
  localparam int unsigned RegW     = 63;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgIdxW  = 3;

  // Damping factor 0.99 in Q0.16 and the floor threshold 0.70711 in Q1.19.
  localparam logic [16:0]        DampQ16   = 17'd64881;
  localparam logic signed [20:0] FloorYQ19 = 21'sd370729;

  localparam logic signed [47:0] SatMax = 48'sd1048575;
  localparam logic signed [47:0] SatMin = -48'sd1048576;

  typedef logic signed [CoordW-1:0] coord_t;

  // Packed register layout: x in bits 20..0, y in 41..21, z in 62..42.
  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } vec3_t;

  typedef enum logic [CfgIdxW-1:0] {
    RegVertexA     = 3'd0,
    RegVertexB     = 3'd1,
    RegVertexC     = 3'd2,
    RegPlaneNormal = 3'd3,
    RegEdgeAb      = 3'd4,
    RegEdgeBc      = 3'd5,
    RegEdgeAc      = 3'd6
  } reg_idx_e;

  // Clamp a wide signed value to the signed 21-bit range.
  function automatic coord_t sat21(input logic signed [47:0] v);
    coord_t r;
    if (v > SatMax) begin
      r = SatMax[CoordW-1:0];
    end else if (v < SatMin) begin
      r = SatMin[CoordW-1:0];
    end else begin
      r = v[CoordW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/stcs_if.sv @@
// ----------------------------------------------------------------------------
// stcs_if
// Valid/ready channels: sphere items, collision results and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface stcs_item_if;
  import stcs_pkg::*;
  logic               valid;
  logic               ready;
  coord_t             pos_x;
  coord_t             pos_y;
  coord_t             pos_z;
  coord_t             vel_x;
  coord_t             vel_y;
  coord_t             vel_z;
  logic [RadW-1:0]    sphere_radius;
  logic [DtW-1:0]     time_step;
  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  sphere_radius, time_step, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                sphere_radius, time_step, output ready);
endinterface

interface stcs_result_if;
  import stcs_pkg::*;
  logic   valid;
  logic   ready;
  logic   hit;
  coord_t new_pos_x;
  coord_t new_pos_y;
  coord_t new_pos_z;
  coord_t new_vel_x;
  coord_t new_vel_y;
  coord_t new_vel_z;
  logic   grounded;
  modport source (output valid, hit, new_pos_x, new_pos_y, new_pos_z, new_vel_x,
                  new_vel_y, new_vel_z, grounded, input ready);
  modport sink (input valid, hit, new_pos_x, new_pos_y, new_pos_z, new_vel_x,
                new_vel_y, new_vel_z, grounded, output ready);
endinterface

interface stcs_cfg_if;
  import stcs_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sphere_triangle_collision_step.sv @@
// ----------------------------------------------------------------------------
// sphere_triangle_collision_step
// Predicts a sphere's next position, tests it against one configured
// triangle and applies the collision response in a six-stage pipeline.
// ----------------------------------------------------------------------------
//  Channel   Dir  Contents
//  item_i    in   pos_x/y/z, vel_x/y/z, sphere_radius, time_step
//  result_o  out  hit, new_pos_x/y/z, new_vel_x/y/z, grounded
//  cfg_i     in   index (3 bits), data (bit 63 ignored), always ready
//
//  An accepted item passes stage registers 1 to 5 and the output register;
//  one item enters per cycle unless the output stalls. All stages advance
//  together whenever the output register is empty or its transaction
//  completes, so a stall freezes the whole pipeline. Reset clears the stage
//  valid bits and the triangle registers. The multiplier stages set the depth.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sphere_triangle_collision_step (
  input  wire           clk_i,
  input  wire           rst_ni,
  stcs_item_if.sink     item_i,
  stcs_result_if.source result_o,
  stcs_cfg_if.sink      cfg_i
);
  import stcs_pkg::*;

  // Triangle registers.
  vec3_t va_q, vb_q, vc_q, nrm_q, eab_q, ebc_q, eac_q;
  coord_t va[3], vb[3], vc[3], nrm[3], eab[3], ebc[3], eac[3];
  coord_t in_pos[3], in_vel[3];

  logic adv;

  // Stage registers.
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q, out_vld_q;
  coord_t s1_pos_q[3], s2_pos_q[3], s3_pos_q[3], s4_pos_q[3], s5_pos_q[3];
  coord_t s1_vel_q[3], s2_vel_q[3], s3_vel_q[3], s4_vel_q[3], s5_vel_q[3];
  logic [RadW-1:0] s1_rad_q, s2_rad_q, s3_rad_q;
  logic signed [37:0] s1_vdt_q[3];
  logic signed [41:0] s1_vnp_q[3];
  logic signed [21:0] s2_nxt_q[3], s3_nxt_q[3], s4_nxt_q[3], s5_nxt_q[3];
  logic signed [22:0] s2_da_q[3], s2_db_q[3], s2_dc_q[3];
  logic signed [24:0] s2_vn_q;
  logic signed [43:0] s3_pab_q[3], s3_pbc_q[3], s3_pac_q[3], s3_ppl_q[3];
  logic signed [45:0] s3_pnv_q[3];
  logic s4_hit_q, s5_hit_q, s4_flr_q, s5_flr_q;
  logic [38:0] s4_dr_q;
  logic signed [28:0] s4_v_q[3], s5_v_q[3];
  logic signed [41:0] s5_plo_q[3];
  logic signed [40:0] s5_phi_q[3];
  logic signed [46:0] s5_vd_q[3];

  logic hit_q, grounded_q;
  coord_t opos_q[3], ovel_q[3];

  // Combinational stage results.
  logic signed [21:0] s2_nxt_d[3];
  logic signed [22:0] s2_da_d[3], s2_db_d[3], s2_dc_d[3];
  logic signed [24:0] s2_vn_d;
  logic signed [28:0] s4_v_d[3];
  logic s4_hit_d, s4_flr_d;
  logic [38:0] s4_dr_d;
  coord_t opos_d[3], ovel_d[3];

  always_comb begin
    va[0] = va_q.x;   va[1] = va_q.y;   va[2] = va_q.z;
    vb[0] = vb_q.x;   vb[1] = vb_q.y;   vb[2] = vb_q.z;
    vc[0] = vc_q.x;   vc[1] = vc_q.y;   vc[2] = vc_q.z;
    nrm[0] = nrm_q.x; nrm[1] = nrm_q.y; nrm[2] = nrm_q.z;
    eab[0] = eab_q.x; eab[1] = eab_q.y; eab[2] = eab_q.z;
    ebc[0] = ebc_q.x; ebc[1] = ebc_q.y; ebc[2] = ebc_q.z;
    eac[0] = eac_q.x; eac[1] = eac_q.y; eac[2] = eac_q.z;
    in_pos[0] = item_i.pos_x; in_pos[1] = item_i.pos_y; in_pos[2] = item_i.pos_z;
    in_vel[0] = item_i.vel_x; in_vel[1] = item_i.vel_y; in_vel[2] = item_i.vel_z;
  end

  // Register writes; indexes beyond the list are dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= '0; vb_q <= '0; vc_q <= '0; nrm_q <= '0;
      eab_q <= '0; ebc_q <= '0; eac_q <= '0;
    end else if (cfg_i.valid) begin
      case (reg_idx_e'(cfg_i.index))
        RegVertexA:     va_q  <= vec3_t'(cfg_i.data[RegW-1:0]);
        RegVertexB:     vb_q  <= vec3_t'(cfg_i.data[RegW-1:0]);
        RegVertexC:     vc_q  <= vec3_t'(cfg_i.data[RegW-1:0]);
        RegPlaneNormal: nrm_q <= vec3_t'(cfg_i.data[RegW-1:0]);
        RegEdgeAb:      eab_q <= vec3_t'(cfg_i.data[RegW-1:0]);
        RegEdgeBc:      ebc_q <= vec3_t'(cfg_i.data[RegW-1:0]);
        RegEdgeAc:      eac_q <= vec3_t'(cfg_i.data[RegW-1:0]);
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the output register can take a new result.
  assign adv          = !out_vld_q || result_o.ready;
  assign item_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0; s2_vld_q <= 1'b0; s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0; s5_vld_q <= 1'b0; out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= item_i.valid;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      s5_vld_q  <= s4_vld_q;
      out_vld_q <= s5_vld_q;
    end
  end

  // Stage 2: predicted position, offsets from the vertices, normal speed.
  always_comb begin
    logic signed [38:0] rv;
    logic signed [43:0] vs;
    vs = 44'(s1_vnp_q[0]) + 44'(s1_vnp_q[1]) + 44'(s1_vnp_q[2]) + 44'sd262144;
    s2_vn_d = vs[43:19];
    for (int i = 0; i < 3; i++) begin
      rv = 39'(s1_vdt_q[i]) + 39'sd32768;
      s2_nxt_d[i] = 22'(s1_pos_q[i]) + rv[37:16];
      s2_da_d[i]  = 23'(s2_nxt_d[i]) - 23'(va[i]);
      s2_db_d[i]  = 23'(s2_nxt_d[i]) - 23'(vb[i]);
      s2_dc_d[i]  = 23'(s2_nxt_d[i]) - 23'(vc[i]);
    end
  end

  // Stage 4: distance sums, hit test, velocity with the normal part removed.
  always_comb begin
    logic signed [45:0] dpl, dab, dbc, dac, rad27;
    logic signed [46:0] rn;
    dpl = 46'(s3_ppl_q[0]) + 46'(s3_ppl_q[1]) + 46'(s3_ppl_q[2]);
    dab = 46'(s3_pab_q[0]) + 46'(s3_pab_q[1]) + 46'(s3_pab_q[2]);
    dbc = 46'(s3_pbc_q[0]) + 46'(s3_pbc_q[1]) + 46'(s3_pbc_q[2]);
    dac = 46'(s3_pac_q[0]) + 46'(s3_pac_q[1]) + 46'(s3_pac_q[2]);
    rad27 = $signed({7'd0, s3_rad_q, 19'd0});
    s4_hit_d = (dpl < rad27) && (dpl > 46'sd0) && (dab > 46'sd0) &&
               (dbc > 46'sd0) && (dac > 46'sd0);
    s4_flr_d = nrm[1] > FloorYQ19;
    s4_dr_d  = 39'(rad27 - dpl);
    for (int i = 0; i < 3; i++) begin
      rn = 47'(s3_pnv_q[i]) + 47'sd262144;
      s4_v_d[i] = 29'(s3_vel_q[i]) - 29'($signed(rn[46:19]));
    end
  end

  // Stage 6: push-out, damping, saturation and the miss echo.
  always_comb begin
    logic signed [61:0] pr;
    logic signed [23:0] p;
    logic signed [47:0] vr;
    for (int i = 0; i < 3; i++) begin
      pr = (62'(s5_phi_q[i]) <<< 20) + 62'(s5_plo_q[i]) + 62'sd137438953472;
      p  = 24'(s5_nxt_q[i]) + 24'(pr[61:38]);
      vr = 48'(s5_vd_q[i]) + 48'sd32768;
      if (s5_hit_q) begin
        opos_d[i] = sat21(48'(p));
        ovel_d[i] = s5_flr_q ? sat21(48'($signed(vr[47:16]))) : sat21(48'(s5_v_q[i]));
      end else begin
        opos_d[i] = s5_pos_q[i];
        ovel_d[i] = s5_vel_q[i];
      end
    end
  end

  // Payload registers of all stages.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      // Stage 1: first products.
      s1_rad_q <= item_i.sphere_radius;
      for (int i = 0; i < 3; i++) begin
        s1_pos_q[i] <= in_pos[i];
        s1_vel_q[i] <= in_vel[i];
        s1_vdt_q[i] <= in_vel[i] * $signed({1'b0, item_i.time_step});
        s1_vnp_q[i] <= in_vel[i] * nrm[i];
      end
      // Stage 2.
      s2_rad_q <= s1_rad_q;
      s2_vn_q  <= s2_vn_d;
      for (int i = 0; i < 3; i++) begin
        s2_pos_q[i] <= s1_pos_q[i];
        s2_vel_q[i] <= s1_vel_q[i];
        s2_nxt_q[i] <= s2_nxt_d[i];
        s2_da_q[i]  <= s2_da_d[i];
        s2_db_q[i]  <= s2_db_d[i];
        s2_dc_q[i]  <= s2_dc_d[i];
      end
      // Stage 3: distance and normal products.
      s3_rad_q <= s2_rad_q;
      for (int i = 0; i < 3; i++) begin
        s3_pos_q[i] <= s2_pos_q[i];
        s3_vel_q[i] <= s2_vel_q[i];
        s3_nxt_q[i] <= s2_nxt_q[i];
        s3_pab_q[i] <= eab[i] * s2_da_q[i];
        s3_pbc_q[i] <= ebc[i] * s2_db_q[i];
        s3_pac_q[i] <= eac[i] * s2_dc_q[i];
        s3_ppl_q[i] <= nrm[i] * s2_da_q[i];
        s3_pnv_q[i] <= nrm[i] * s2_vn_q;
      end
      // Stage 4.
      s4_hit_q <= s4_hit_d;
      s4_flr_q <= s4_flr_d;
      s4_dr_q  <= s4_dr_d;
      for (int i = 0; i < 3; i++) begin
        s4_pos_q[i] <= s3_pos_q[i];
        s4_vel_q[i] <= s3_vel_q[i];
        s4_nxt_q[i] <= s3_nxt_q[i];
        s4_v_q[i]   <= s4_v_d[i];
      end
      // Stage 5: push-out partial products and damping product.
      s5_hit_q <= s4_hit_q;
      s5_flr_q <= s4_flr_q;
      for (int i = 0; i < 3; i++) begin
        s5_pos_q[i] <= s4_pos_q[i];
        s5_vel_q[i] <= s4_vel_q[i];
        s5_nxt_q[i] <= s4_nxt_q[i];
        s5_v_q[i]   <= s4_v_q[i];
        s5_plo_q[i] <= nrm[i] * $signed({1'b0, s4_dr_q[19:0]});
        s5_phi_q[i] <= nrm[i] * $signed({1'b0, s4_dr_q[38:20]});
        s5_vd_q[i]  <= s4_v_q[i] * $signed({1'b0, DampQ16});
      end
      // Output register.
      hit_q      <= s5_hit_q;
      grounded_q <= s5_hit_q && s5_flr_q;
      for (int i = 0; i < 3; i++) begin
        opos_q[i] <= opos_d[i];
        ovel_q[i] <= ovel_d[i];
      end
    end
  end

  assign result_o.valid     = out_vld_q;
  assign result_o.hit       = hit_q;
  assign result_o.grounded  = grounded_q;
  assign result_o.new_pos_x = opos_q[0];
  assign result_o.new_pos_y = opos_q[1];
  assign result_o.new_pos_z = opos_q[2];
  assign result_o.new_vel_x = ovel_q[0];
  assign result_o.new_vel_y = ovel_q[1];
  assign result_o.new_vel_z = ovel_q[2];

endmodule

`default_nettype wire

@@ rtl/core/stcs_checker.sv @@
// ----------------------------------------------------------------------------
// stcs_checker
// Port-level checks on the collision step, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stcs_checker (
  input wire clk_i,
  input wire rst_ni,
  input wire in_ready_i,
  input wire out_valid_i,
  input wire out_ready_i,
  input wire out_hit_i,
  input wire out_grounded_i,
  input wire cfg_ready_i
);

  // A result that is not taken stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // A landing is always a hit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_hit_i || !out_grounded_i))
    else $error("grounded without hit");

  // The input side only waits while a result is stalled at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_i && !out_ready_i) |-> in_ready_i)
    else $error("input stalled without output backpressure");

  // The register port never pushes back.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_i)
    else $error("register port not ready");

endmodule

bind sphere_triangle_collision_step stcs_checker u_stcs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (item_i.ready),
  .out_valid_i    (result_o.valid),
  .out_ready_i    (result_o.ready),
  .out_hit_i      (result_o.hit),
  .out_grounded_i (result_o.grounded),
  .cfg_ready_i    (cfg_i.ready)
);

`default_nettype wire

@@ sim/tb_sphere_triangle_collision_step.sv @@
// ----------------------------------------------------------------------------
// tb_sphere_triangle_collision_step
// Self-checking bench for the sphere and triangle collision step. A local
// fixed-point predictor computes each expected result. Items are sent through
// several idling phases and under several triangle settings, and every
// result is compared field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sphere_triangle_collision_step;
  import stcs_pkg::*;

  typedef struct packed {
    logic   hit;
    coord_t px;
    coord_t py;
    coord_t pz;
    coord_t vx;
    coord_t vy;
    coord_t vz;
    logic   grounded;
  } response_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  stcs_item_if   item_ch ();
  stcs_result_if res_ch ();
  stcs_cfg_if    cfg_ch ();

  sphere_triangle_collision_step dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_ch.sink),
    .result_o(res_ch.source),
    .cfg_i   (cfg_ch.sink)
  );

  always #2 clk_i = ~clk_i;

  // Triangle registers as seen by the predictor.
  logic [RegW-1:0] tri_regs [7];
  response_t expected_q [$];
  int unsigned send_pct;
  int unsigned stall_pct;
  int unsigned errors = 0;
  int unsigned n_items = 0;
  int unsigned n_hits = 0;
  int unsigned n_ground = 0;
  longint unsigned cycles = 0;

  // Round half up of x / 2^s.
  function automatic longint rnd_shr(input longint x, input int s);
    longint y;
    y = x + (longint'(1) <<< (s - 1));
    return y >>> s;
  endfunction

  function automatic longint clamp21(input longint v);
    if (v > 1048575) return 1048575;
    if (v < -1048576) return -1048576;
    return v;
  endfunction

  function automatic longint fld(input logic [RegW-1:0] r, input int k);
    coord_t c;
    c = r[k*21 +: 21];
    return longint'(c);
  endfunction

  function automatic response_t predict_response(input coord_t p [3], input coord_t v [3],
                                                 input logic [19:0] rad,
                                                 input logic [15:0] dt);
    response_t o;
    longint nx [3];
    longint dpl, dab, dbc, dac, r27, vn, dr, vv, pp;
    logic flr;
    dpl = 0; dab = 0; dbc = 0; dac = 0;
    for (int i = 0; i < 3; i++) begin
      nx[i] = longint'(p[i]) + rnd_shr(longint'(v[i]) * longint'(dt), 16);
      dpl += fld(tri_regs[RegPlaneNormal], i) * (nx[i] - fld(tri_regs[RegVertexA], i));
      dab += fld(tri_regs[RegEdgeAb], i) * (nx[i] - fld(tri_regs[RegVertexA], i));
      dbc += fld(tri_regs[RegEdgeBc], i) * (nx[i] - fld(tri_regs[RegVertexB], i));
      dac += fld(tri_regs[RegEdgeAc], i) * (nx[i] - fld(tri_regs[RegVertexC], i));
    end
    r27 = longint'(rad) * 524288;
    o = '0;
    if (dpl < r27 && dpl > 0 && dab > 0 && dbc > 0 && dac > 0) begin
      vn = 0;
      for (int i = 0; i < 3; i++) vn += longint'(v[i]) * fld(tri_regs[RegPlaneNormal], i);
      vn = rnd_shr(vn, 19);
      dr = r27 - dpl;
      flr = fld(tri_regs[RegPlaneNormal], 1) > longint'(FloorYQ19);
      o.hit = 1'b1;
      o.grounded = flr;
      for (int i = 0; i < 3; i++) begin
        vv = longint'(v[i]) - rnd_shr(fld(tri_regs[RegPlaneNormal], i) * vn, 19);
        pp = nx[i] + rnd_shr(fld(tri_regs[RegPlaneNormal], i) * dr, 38);
        if (flr) vv = rnd_shr(vv * 64881, 16);
        vv = clamp21(vv);
        pp = clamp21(pp);
        case (i)
          0: begin o.px = pp[20:0]; o.vx = vv[20:0]; end
          1: begin o.py = pp[20:0]; o.vy = vv[20:0]; end
          default: begin o.pz = pp[20:0]; o.vz = vv[20:0]; end
        endcase
      end
    end else begin
      o.px = p[0]; o.py = p[1]; o.pz = p[2];
      o.vx = v[0]; o.vy = v[1]; o.vz = v[2];
    end
    return o;
  endfunction

  // Send one sphere; the prediction is queued at acceptance. Valid stays
  // high after the transaction so that items can follow back to back.
  task automatic send_sphere(input coord_t p [3], input coord_t v [3],
                             input logic [19:0] rad, input logic [15:0] dt);
    while ($urandom_range(99) >= send_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_ch.valid <= 1'b1;
    item_ch.pos_x <= p[0]; item_ch.pos_y <= p[1]; item_ch.pos_z <= p[2];
    item_ch.vel_x <= v[0]; item_ch.vel_y <= v[1]; item_ch.vel_z <= v[2];
    item_ch.sphere_radius <= rad;
    item_ch.time_step <= dt;
    do @(posedge clk_i); while (!item_ch.ready);
    expected_q.push_back(predict_response(p, v, rad, dt));
    n_items++;
  endtask

  // Waits until the pipeline has drained, then writes one register.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    item_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    if (idx < 7) tri_regs[idx] = val[62:0];
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [63:0] pack3(input longint x, input longint y, input longint z);
    logic [63:0] r;
    r = '0;
    r[20:0] = x[20:0]; r[41:21] = y[20:0]; r[62:42] = z[20:0];
    return r;
  endfunction

  // Floor triangle in the y = 0 plane, corners (0,0,0) (L,0,0) (0,0,L).
  task automatic load_triangle(input longint len, input longint ny_q19, input logic bit63);
    longint s;
    s = 370728; // 1/sqrt(2) in Q1.19
    write_reg(RegVertexA, pack3(0, 0, 0));
    write_reg(RegVertexB, pack3(len, 0, 0));
    write_reg(RegVertexC, pack3(0, 0, len) | (64'(bit63) << 63));
    write_reg(RegPlaneNormal, pack3(0, ny_q19, 0));
    write_reg(RegEdgeAb, pack3(0, 0, 524287));
    write_reg(RegEdgeBc, pack3(-s, 0, -s));
    write_reg(RegEdgeAc, pack3(524287, 0, 0));
  endtask

  function automatic coord_t rnd21();
    return coord_t'($urandom);
  endfunction

  // A sphere that sits near the triangle, mostly hitting.
  task automatic send_near(input longint len);
    coord_t p [3], v [3];
    p[0] = coord_t'($urandom_range(32'(len / 3)));
    p[2] = coord_t'($urandom_range(32'(len / 3)));
    p[1] = coord_t'($urandom_range(300));
    for (int i = 0; i < 3; i++) v[i] = coord_t'(int'($urandom_range(4000)) - 2000);
    send_sphere(p, v, 20'($urandom_range(600)), 16'($urandom_range(2000)));
  endtask

  task automatic send_noise();
    coord_t p [3], v [3];
    for (int i = 0; i < 3; i++) begin p[i] = rnd21(); v[i] = rnd21(); end
    send_sphere(p, v, 20'($urandom), 16'($urandom));
  endtask

  task automatic test_reset_state();
    coord_t p [3], v [3];
    p = '{21'sd100, 21'sd5, -21'sd7};
    v = '{-21'sd1048576, 21'sd1048575, 21'sd0};
    send_sphere(p, v, 20'hFFFFF, 16'hFFFF);
  endtask

  task automatic test_directed();
    coord_t p [3], v [3];
    load_triangle(4096, 524287, 1'b1);
    // Plain floor hit, then zero radius and touching-plane cases.
    p = '{21'sd256, 21'sd100, 21'sd256}; v = '{21'sd500, -21'sd800, 21'sd300};
    send_sphere(p, v, 20'd256, 16'd0);
    send_sphere(p, v, 20'd0, 16'd0);
    p = '{21'sd256, 21'sd0, 21'sd256};
    send_sphere(p, v, 20'd256, 16'd0);
    // Outside edge and above radius.
    p = '{21'sd4000, 21'sd100, 21'sd4000};
    send_sphere(p, v, 20'd256, 16'd0);
    p = '{21'sd256, 21'sd300, 21'sd256};
    send_sphere(p, v, 20'd256, 16'd0);
    // Saturating velocities and a full time step.
    p = '{21'sd256, 21'sd10, 21'sd256};
    v = '{21'sd1048575, -21'sd1048576, -21'sd1048576};
    send_sphere(p, v, 20'hFFFFF, 16'd0);
    v = '{21'sd1000, 21'sd0, 21'sd1000};
    send_sphere(p, v, 20'd512, 16'hFFFF);
    // Large radius pushes position beyond range.
    p = '{21'sd256, 21'sd1, 21'sd256}; v = '{-21'sd1048576, 21'sd1048575, 21'sd0};
    send_sphere(p, v, 20'hFFFFF, 16'd1);
    // Steep face: non-floor hit; threshold boundary values.
    load_triangle(4096, 370729, 1'b0);
    p = '{21'sd256, 21'sd100, 21'sd256}; v = '{21'sd500, -21'sd800, 21'sd300};
    send_sphere(p, v, 20'd256, 16'd0);
    write_reg(RegPlaneNormal, pack3(0, 370730, 0));
    send_sphere(p, v, 20'd256, 16'd0);
    // Negative normal: flipped side, never a hit from above.
    write_reg(RegPlaneNormal, pack3(0, -524288, 0));
    send_sphere(p, v, 20'd256, 16'd0);
    // Index beyond the list is ignored.
    write_reg(3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
    send_sphere(p, v, 20'd256, 16'd0);
  endtask

  task automatic test_random_phase(input int unsigned sp, input int unsigned rp,
                                   input longint len, input longint ny, input int cnt);
    send_pct = sp;
    stall_pct = rp;
    load_triangle(len, ny, cnt[0]);
    for (int k = 0; k < cnt; k++) begin
      if ($urandom_range(9) < 7) send_near(len);
      else send_noise();
    end
  endtask

  // Random extreme register contents, mostly noise.
  task automatic test_random_regs();
    for (int r = 0; r < 7; r++)
      write_reg(3'(r), {$urandom, $urandom});
    for (int k = 0; k < 40; k++) send_noise();
  endtask

  // Receiver: random stalls and ordered field checks.
  always @(posedge clk_i) begin
    response_t got, exp_r;
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (res_ch.valid && res_ch.ready) begin
        got = {res_ch.hit, res_ch.new_pos_x, res_ch.new_pos_y, res_ch.new_pos_z,
               res_ch.new_vel_x, res_ch.new_vel_y, res_ch.new_vel_z, res_ch.grounded};
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %h", $time, got);
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            errors++;
            $display("%0t: mismatch expected hit=%b p=%0d,%0d,%0d v=%0d,%0d,%0d g=%b",
                     $time, exp_r.hit, exp_r.px, exp_r.py, exp_r.pz,
                     exp_r.vx, exp_r.vy, exp_r.vz, exp_r.grounded);
            $display("%0t:          actual   hit=%b p=%0d,%0d,%0d v=%0d,%0d,%0d g=%b",
                     $time, got.hit, got.px, got.py, got.pz,
                     got.vx, got.vy, got.vz, got.grounded);
          end
          if (exp_r.hit) n_hits++;
          if (exp_r.grounded) n_ground++;
        end
      end
      res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Timeout watchdog.
  always @(posedge clk_i) begin
    if (cycles > 64'd900000) begin
      $display("tb_sphere_triangle_collision_step: done, errors");
      $finish;
    end
  end

  initial begin
    item_ch.valid = 1'b0;
    item_ch.pos_x = '0; item_ch.pos_y = '0; item_ch.pos_z = '0;
    item_ch.vel_x = '0; item_ch.vel_y = '0; item_ch.vel_z = '0;
    item_ch.sphere_radius = '0; item_ch.time_step = '0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    for (int r = 0; r < 7; r++) tri_regs[r] = '0;
    send_pct = 100;
    stall_pct = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_directed();
    test_random_phase(100, 0, 4096, 524287, 200);
    test_random_phase(13, 0, 1048575, 400000, 160);
    test_random_phase(100, 87, 512, 370729, 160);
    test_random_phase(62, 38, 100000, 300000, 200);
    test_random_regs();
    item_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Covered %0d spheres: %0d hits, %0d grounded, four idling phases.",
             n_items, n_hits, n_ground);
    if (errors == 0) begin
      $display("tb_sphere_triangle_collision_step: done, clean");
    end else begin
      $display("tb_sphere_triangle_collision_step: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/stcs_pkg.sv
rtl/core/stcs_if.sv
rtl/core/sphere_triangle_collision_step.sv
rtl/core/stcs_checker.sv
sim/tb_sphere_triangle_collision_step.sv
